### rtl/gga_pkg.sv
`timescale 1ns / 1ps
package gga_pkg;

  localparam int FRAC_BITS   = 12;
  localparam int LUT_ENTRIES = 256;
  localparam int DOM_LOG2    = 3;
  localparam int WB          = 24;
  localparam int IDX_SHIFT   = FRAC_BITS + DOM_LOG2;
  localparam int FRAC_W      = IDX_SHIFT - $clog2(LUT_ENTRIES);
  localparam int IDX_W       = $clog2(LUT_ENTRIES + 1);
  localparam int DATA_W      = 16;
  localparam int TAB_W       = 17;
  localparam int A_W         = 19;
  localparam int SQ_W        = 31;
  localparam int NQ_W        = 46;
  localparam int M_W         = 31;
  localparam int W_W         = 20;
  localparam int C_W         = 23;
  localparam int SUM_W       = 24;
  localparam int PROD_W      = 40;

  localparam longint unsigned ONE_W      = 64'd1 << WB;
  localparam longint unsigned SQ2PI_W    = 64'd13386282;
  localparam longint unsigned CUBIC_NUM  = 64'd44715;
  localparam longint unsigned CUBIC_DEN  = 64'd1000000;
  localparam int unsigned     SQ2PI_Q    = 52290;
  localparam int unsigned     CUBIC3_RED = 26829;
  localparam int unsigned     W_BIAS     = 25600000;
  localparam int              W_SHIFT    = 14;
  localparam int              RECIP_K    = 44;
  localparam longint unsigned RECIP      = ((64'd1 << RECIP_K) + 64'd3124) / 64'd3125;
  localparam int unsigned     Q16_ONE    = 65536;
  localparam int unsigned     Q16_HALF   = 32768;

  localparam logic MODE_ERF  = 1'b0;
  localparam logic MODE_TANH = 1'b1;

  localparam int TAB_ERF   = 0;
  localparam int TAB_GAUSS = 1;
  localparam int TAB_TANH  = 2;

  typedef logic [TAB_W-1:0] tab_t [0:LUT_ENTRIES];

  typedef struct packed {
    logic signed [DATA_W-1:0] activation_in;
    logic signed [DATA_W-1:0] upstream_grad;
    logic signed [DATA_W-1:0] accum_grad_in;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] accum_grad_out;
    logic                     saturated;
  } out_t;

  typedef struct packed {
    logic [TAB_W-1:0] t0;
    logic [TAB_W-1:0] t1;
    logic [TAB_W-1:0] g0;
    logic [TAB_W-1:0] g1;
  } lut_rd_t;

  typedef struct packed {
    logic signed [SUM_W-1:0]  sum2;
    logic signed [DATA_W-1:0] up;
    logic signed [DATA_W-1:0] acc;
  } acc_req_t;

  // Shift-and-subtract quotient, used only while the tables are built.
  function automatic longint unsigned div_u64(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned rem;
    q   = 64'd0;
    rem = 64'd0;
    for (int i = 63; i >= 0; i--) begin
      rem = (rem << 1) | ((n >> i) & 64'd1);
      q   = q << 1;
      if (rem >= d) begin
        rem = rem - d;
        q   = q | 64'd1;
      end
    end
    return q;
  endfunction

  function automatic longint unsigned series_neg(longint unsigned r);
    longint          sum;
    longint unsigned term;
    sum  = longint'(ONE_W);
    term = ONE_W;
    for (int k = 1; k <= 16; k++) begin
      term = div_u64((term * r) >> WB, 64'(k));
      if ((k & 1) != 0) sum = sum - longint'(term);
      else sum = sum + longint'(term);
    end
    return (sum < 0) ? 64'd0 : longint'(sum);
  endfunction

  function automatic longint unsigned exp_neg(longint unsigned s);
    longint unsigned n;
    longint unsigned res;
    longint unsigned e1;
    n = s >> WB;
    if (n > 40) return 64'd0;
    res = series_neg(s & (ONE_W - 64'd1));
    e1  = series_neg(ONE_W);
    for (longint unsigned k = 0; k < n; k++) begin
      res = (res * e1 + (ONE_W >> 1)) >> WB;
    end
    return res;
  endfunction

  function automatic logic [TAB_W-1:0] to_q16(longint unsigned v);
    longint unsigned r;
    r = (v + 64'd128) >> 8;
    return (r > 64'd65536) ? TAB_W'(65536) : TAB_W'(r);
  endfunction

  function automatic tab_t build_tab(int sel);
    tab_t            t;
    longint unsigned acc;
    longint unsigned f0;
    longint unsigned a;
    longint unsigned a2;
    longint unsigned a3;
    longint unsigned poly;
    longint unsigned u;
    longint unsigned e;
    longint unsigned m;
    longint unsigned fm;
    longint unsigned a1;
    longint unsigned f1;
    longint unsigned integ;
    acc  = 64'd0;
    f0   = exp_neg(64'd0);
    t[0] = '0;
    for (int i = 0; i <= LUT_ENTRIES; i++) begin
      a    = (longint'(i) << (WB + DOM_LOG2)) / LUT_ENTRIES;
      a2   = (a * a) >> WB;
      a3   = (a2 * a) >> WB;
      poly = a + a3 * CUBIC_NUM / CUBIC_DEN;
      u    = (poly * SQ2PI_W) >> WB;
      e    = exp_neg(2 * u);
      if (sel == TAB_GAUSS) t[i] = to_q16(exp_neg(a2 >> 1));
      if (sel == TAB_TANH) t[i] = to_q16(div_u64((ONE_W - e) << WB, ONE_W + e));
      if (i < LUT_ENTRIES) begin
        m     = ((2 * longint'(i) + 1) << (WB + DOM_LOG2 - 1)) / LUT_ENTRIES;
        fm    = exp_neg(((m * m) >> WB) >> 1);
        a1    = (longint'(i + 1) << (WB + DOM_LOG2)) / LUT_ENTRIES;
        f1    = exp_neg(((a1 * a1) >> WB) >> 1);
        acc   = acc + f0 + 4 * fm + f1;
        integ = (4 * acc) / (3 * LUT_ENTRIES);
        if (sel == TAB_ERF) t[i+1] = to_q16((integ * SQ2PI_W) >> WB);
        f0 = f1;
      end
    end
    return t;
  endfunction

  function automatic logic [TAB_W-1:0] lerp(logic [TAB_W-1:0] a, logic [TAB_W-1:0] b,
                                             logic [FRAC_W-1:0] f);
    logic [TAB_W-1:0]        diff;
    logic [TAB_W+FRAC_W-1:0] step;
    diff = (b >= a) ? (b - a) : (a - b);
    step = ((TAB_W+FRAC_W)'(diff) * (TAB_W+FRAC_W)'(f) + (TAB_W+FRAC_W)'(64)) >> FRAC_W;
    return (b >= a) ? (a + TAB_W'(step)) : (a - TAB_W'(step));
  endfunction

endpackage

### rtl/gga_lut.sv
`timescale 1ns / 1ps
module gga_lut (
  input  logic [gga_pkg::IDX_W-1:0] idx_i,
  input  logic                      mode_i,
  output gga_pkg::lut_rd_t          rd_o
);

  localparam gga_pkg::tab_t ErfTab   = gga_pkg::build_tab(gga_pkg::TAB_ERF);
  localparam gga_pkg::tab_t GaussTab = gga_pkg::build_tab(gga_pkg::TAB_GAUSS);
  localparam gga_pkg::tab_t TanhTab  = gga_pkg::build_tab(gga_pkg::TAB_TANH);

  logic [gga_pkg::IDX_W-1:0] idx1;

  assign idx1 = (idx_i == gga_pkg::IDX_W'(gga_pkg::LUT_ENTRIES)) ? idx_i
                                                                : idx_i + 1'b1;

  always_comb begin
    if (mode_i == gga_pkg::MODE_TANH) begin
      rd_o.t0 = TanhTab[idx_i];
      rd_o.t1 = TanhTab[idx1];
    end else begin
      rd_o.t0 = ErfTab[idx_i];
      rd_o.t1 = ErfTab[idx1];
    end
    rd_o.g0 = GaussTab[idx_i];
    rd_o.g1 = GaussTab[idx1];
  end

endmodule

### rtl/gga_acc.sv
`timescale 1ns / 1ps
module gga_acc (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  gga_pkg::acc_req_t req_i,
  output logic              valid_o,
  output gga_pkg::out_t     out_o
);

  logic                                 p_valid_q;
  logic signed [gga_pkg::PROD_W-1:0]    prod_q, prod_d;
  logic signed [gga_pkg::DATA_W-1:0]    acc_q;
  logic        [gga_pkg::PROD_W-1:0]    mag;
  logic        [gga_pkg::SUM_W-2:0]     rnd;
  logic signed [gga_pkg::SUM_W-1:0]     delta;
  logic signed [gga_pkg::SUM_W:0]       total;
  logic                                 o_valid_q;
  gga_pkg::out_t                        out_q, out_d;

  assign prod_d = gga_pkg::PROD_W'(req_i.up) * gga_pkg::PROD_W'(req_i.sum2);

  always_comb begin
    mag   = prod_q[gga_pkg::PROD_W-1] ? gga_pkg::PROD_W'(-prod_q) : prod_q;
    rnd   = (gga_pkg::SUM_W-1)'((mag + gga_pkg::PROD_W'(65536)) >> 17);
    delta = prod_q[gga_pkg::PROD_W-1] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
    total = (gga_pkg::SUM_W+1)'(acc_q) + (gga_pkg::SUM_W+1)'(delta);
    out_d.saturated = 1'b0;
    if (total > (gga_pkg::SUM_W+1)'(32767)) begin
      out_d.accum_grad_out = 16'sd32767;
      out_d.saturated      = 1'b1;
    end else if (total < -(gga_pkg::SUM_W+1)'(32768)) begin
      out_d.accum_grad_out = -16'sd32768;
      out_d.saturated      = 1'b1;
    end else begin
      out_d.accum_grad_out = gga_pkg::DATA_W'(total);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
    end else begin
      p_valid_q <= valid_i;
      o_valid_q <= p_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    acc_q  <= req_i.acc;
    out_q  <= out_d;
  end

  assign valid_o = o_valid_q;
  assign out_o   = out_q;

endmodule

### rtl/gelu_gradient_accumulate_core.sv
`timescale 1ns / 1ps
// Each item passes through the core stages and then the product and output registers of gga_acc,
// and result_valid_o marks the result when it leaves the output register.
// One item is accepted in every cycle; busy_o stays low, so throughput is one item per cycle.
// The depth is set by the table lookup, the chained multipliers and the final accumulate.
// The receiver cannot stall, so results leave on result_valid_o without back pressure.
// Reset clears all valid bits and sets the mode register to the exact erf form.
module gelu_gradient_accumulate_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_wdata_i,
  input  logic           start_i,
  input  gga_pkg::in_t   in_i,
  output logic           busy_o,
  output logic           result_valid_o,
  output gga_pkg::out_t  out_o
);

  localparam int TW = gga_pkg::TAB_W;
  localparam int DW = gga_pkg::DATA_W;

  logic mode_q;

  // Stage 1: magnitude and table index.
  logic                          s1_valid_q, s1_neg_q, s1_mode_q;
  logic [DW:0]                   s1_ax_q, ax_d;
  logic [gga_pkg::IDX_W-1:0]     s1_idx_q, idx_d;
  logic [gga_pkg::FRAC_W-1:0]    s1_frac_q, frac_d;
  logic signed [DW-1:0]          s1_up_q, s1_acc_q;
  logic [DW-gga_pkg::FRAC_W:0]   idx_full;

  // Stage 2: table reads, scaled magnitude and square.
  logic                          s2_valid_q, s2_neg_q, s2_mode_q;
  logic [gga_pkg::FRAC_W-1:0]    s2_frac_q;
  logic signed [DW-1:0]          s2_up_q, s2_acc_q;
  gga_pkg::lut_rd_t              lut_rd, s2_rd_q;
  logic [gga_pkg::A_W-1:0]       s2_a_q, a_d;
  logic [gga_pkg::SQ_W-1:0]      s2_sq_q;

  // Stage 3: interpolation and cubic term numerator.
  logic                          s3_valid_q, s3_neg_q, s3_mode_q;
  logic signed [DW-1:0]          s3_up_q, s3_acc_q;
  logic [TW-1:0]                 s3_v_q, s3_p_q;
  logic [gga_pkg::A_W-1:0]       s3_a_q;
  logic [gga_pkg::NQ_W-1:0]      s3_nq_q;

  // Stage 4: erf-form correction, tanh-form 1-t^2 and scaled quotient input.
  logic                          s4_valid_q, s4_neg_q, s4_mode_q;
  logic signed [DW-1:0]          s4_up_q, s4_acc_q;
  logic [TW-1:0]                 s4_v_q, s4_d_q, d_d;
  logic [gga_pkg::A_W-1:0]       s4_a_q;
  logic [gga_pkg::C_W-1:0]       s4_c0_q, c0_d;
  logic [gga_pkg::M_W-1:0]       s4_m_q;

  // Stage 5: tanh-form factor and cubic term.
  logic                          s5_valid_q, s5_neg_q, s5_mode_q;
  logic signed [DW-1:0]          s5_up_q, s5_acc_q;
  logic [TW-1:0]                 s5_v_q;
  logic [gga_pkg::C_W-1:0]       s5_c0_q;
  logic [gga_pkg::A_W-1:0]       s5_b_q, b_d;
  logic [gga_pkg::W_W-1:0]       s5_w_q, w_d;

  // Stage 6: twice the derivative.
  logic                          s6_valid_q;
  gga_pkg::acc_req_t             s6_req_q, req_d;
  logic [gga_pkg::W_W:0]         wt;
  logic [gga_pkg::C_W-1:0]       c1, c_sel;
  logic [gga_pkg::SUM_W-1:0]     vc;

  assign busy_o = 1'b0;

  always_comb begin
    ax_d = in_i.activation_in[DW-1] ? (DW+1)'(0) - (DW+1)'(in_i.activation_in)
                                    : (DW+1)'(in_i.activation_in);
    idx_full = ax_d[DW:gga_pkg::FRAC_W];
    if (idx_full >= (DW-gga_pkg::FRAC_W+1)'(gga_pkg::LUT_ENTRIES)) begin
      idx_d  = gga_pkg::IDX_W'(gga_pkg::LUT_ENTRIES);
      frac_d = '0;
    end else begin
      idx_d  = gga_pkg::IDX_W'(idx_full);
      frac_d = ax_d[gga_pkg::FRAC_W-1:0];
    end
  end

  gga_lut u_lut (
    .idx_i  (s1_idx_q),
    .mode_i (s1_mode_q),
    .rd_o   (lut_rd)
  );

  assign a_d = gga_pkg::A_W'((36'(s1_ax_q) * 36'(gga_pkg::SQ2PI_Q) + 36'd2048)
                             >> gga_pkg::FRAC_BITS);

  always_comb begin
    c0_d = gga_pkg::C_W'((36'(s3_a_q) * 36'(s3_p_q) + 36'(gga_pkg::Q16_HALF)) >> 16);
    d_d  = TW'(gga_pkg::Q16_ONE) -
           TW'((34'(s3_v_q) * 34'(s3_v_q) + 34'(gga_pkg::Q16_HALF)) >> 16);
  end

  assign b_d = gga_pkg::A_W'((36'(s4_a_q) * 36'(s4_d_q) + 36'(gga_pkg::Q16_HALF)) >> 16);
  assign w_d = gga_pkg::W_W'((64'(s4_m_q) * 64'(gga_pkg::RECIP)) >> gga_pkg::RECIP_K);

  always_comb begin
    wt    = (gga_pkg::W_W+1)'(s5_w_q) + (gga_pkg::W_W+1)'(gga_pkg::Q16_ONE);
    c1    = gga_pkg::C_W'((40'(s5_b_q) * 40'(wt) + 40'(gga_pkg::Q16_HALF)) >> 16);
    c_sel = (s5_mode_q == gga_pkg::MODE_TANH) ? c1 : s5_c0_q;
    vc    = gga_pkg::SUM_W'(s5_v_q) + gga_pkg::SUM_W'(c_sel);
    req_d.sum2 = s5_neg_q ? $signed(gga_pkg::SUM_W'(gga_pkg::Q16_ONE) - vc)
                          : $signed(gga_pkg::SUM_W'(gga_pkg::Q16_ONE) + vc);
    req_d.up   = s5_up_q;
    req_d.acc  = s5_acc_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= gga_pkg::MODE_ERF;
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
      s6_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) mode_q <= cfg_wdata_i;
      s1_valid_q <= start_i && !busy_o;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
      s5_valid_q <= s4_valid_q;
      s6_valid_q <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_neg_q  <= in_i.activation_in[DW-1];
    s1_mode_q <= mode_q;
    s1_ax_q   <= ax_d;
    s1_idx_q  <= idx_d;
    s1_frac_q <= frac_d;
    s1_up_q   <= in_i.upstream_grad;
    s1_acc_q  <= in_i.accum_grad_in;

    s2_neg_q  <= s1_neg_q;
    s2_mode_q <= s1_mode_q;
    s2_frac_q <= s1_frac_q;
    s2_up_q   <= s1_up_q;
    s2_acc_q  <= s1_acc_q;
    s2_rd_q   <= lut_rd;
    s2_a_q    <= a_d;
    s2_sq_q   <= gga_pkg::SQ_W'(34'(s1_ax_q) * 34'(s1_ax_q));

    s3_neg_q  <= s2_neg_q;
    s3_mode_q <= s2_mode_q;
    s3_up_q   <= s2_up_q;
    s3_acc_q  <= s2_acc_q;
    s3_v_q    <= gga_pkg::lerp(s2_rd_q.t0, s2_rd_q.t1, s2_frac_q);
    s3_p_q    <= gga_pkg::lerp(s2_rd_q.g0, s2_rd_q.g1, s2_frac_q);
    s3_a_q    <= s2_a_q;
    s3_nq_q   <= gga_pkg::NQ_W'(s2_sq_q) * gga_pkg::NQ_W'(gga_pkg::CUBIC3_RED)
               + gga_pkg::NQ_W'(gga_pkg::W_BIAS);

    s4_neg_q  <= s3_neg_q;
    s4_mode_q <= s3_mode_q;
    s4_up_q   <= s3_up_q;
    s4_acc_q  <= s3_acc_q;
    s4_v_q    <= s3_v_q;
    s4_d_q    <= d_d;
    s4_a_q    <= s3_a_q;
    s4_c0_q   <= c0_d;
    s4_m_q    <= gga_pkg::M_W'(s3_nq_q >> gga_pkg::W_SHIFT);

    s5_neg_q  <= s4_neg_q;
    s5_mode_q <= s4_mode_q;
    s5_up_q   <= s4_up_q;
    s5_acc_q  <= s4_acc_q;
    s5_v_q    <= s4_v_q;
    s5_c0_q   <= s4_c0_q;
    s5_b_q    <= b_d;
    s5_w_q    <= w_d;

    s6_req_q  <= req_d;
  end

  gga_acc u_acc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s6_valid_q),
    .req_i   (s6_req_q),
    .valid_o (result_valid_o),
    .out_o   (out_o)
  );

endmodule

### rtl/gga_checker.sv
`timescale 1ns / 1ps
module gga_checker (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          cfg_we_i,
  input logic          cfg_wdata_i,
  input logic          start_i,
  input gga_pkg::in_t  in_i,
  input logic          busy_o,
  input logic          result_valid_o,
  input gga_pkg::out_t out_o
);

  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni) !busy_o)
    else $error("busy asserted");

  a_result_has_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i, 8))
    else $error("result without an accepted item");

  a_sat_at_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && out_o.saturated) |->
      (out_o.accum_grad_out == 16'sd32767 || out_o.accum_grad_out == -16'sd32768))
    else $error("saturated result not at a limit");

  a_zero_grad_passes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && $past(in_i.upstream_grad == 16'sd0, 8)) |->
      (!out_o.saturated && out_o.accum_grad_out == $past(in_i.accum_grad_in, 8)))
    else $error("zero gradient changed the sum");

endmodule

bind gelu_gradient_accumulate_core gga_checker u_gga_checker (.*);
